// ----- src/keyed_deadband_change_filter_core_assert.svh -----
// Assertion macros shared by the change filter modules.
`ifndef KEYED_DEADBAND_CHANGE_FILTER_CORE_ASSERT_SVH
`define KEYED_DEADBAND_CHANGE_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define KDCF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kdcf: property violated");
// Expression must never be true outside reset.
`define KDCF_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("kdcf: forbidden condition seen");
`else
`define KDCF_ASSERT(lbl, prop)
`define KDCF_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ----- src/kdcf_pkg.sv -----
// Types and constants shared by the keyed dead-band change filter.
package kdcf_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int COORD_BITS    = 32;
    localparam int NUM_COORDS    = 7;
    localparam int KEY_W         = 64;
    localparam int THR_W         = 31;
    localparam int LANES         = 4;

    localparam int ROWS       = TABLE_ENTRIES / LANES;
    localparam int LANE_W     = $clog2(LANES);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int IDX_W      = $clog2(TABLE_ENTRIES);
    localparam int FILL_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int ROWCNT_W   = $clog2(ROWS + 1);
    localparam int CIDX_W     = $clog2(NUM_COORDS);
    localparam int DIFF_W     = COORD_BITS + 1;

    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(66);
    localparam logic [CIDX_W-1:0] LAST_COORD = CIDX_W'(NUM_COORDS - 1);

    typedef enum logic [2:0] {
        ST_UNCHANGED   = 3'd0,
        ST_NEW_SKIPPED = 3'd1,
        ST_NEW_DEAD    = 3'd2,
        ST_CHANGED     = 3'd3,
        ST_FULL        = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_DECIDE,
        S_COMPARE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]             actor_key;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic signed [COORD_BITS-1:0] rot_a;
        logic signed [COORD_BITS-1:0] rot_b;
        logic signed [COORD_BITS-1:0] rot_c;
        logic signed [COORD_BITS-1:0] rot_d;
        logic                         is_down;
    } in_item_t;

    typedef struct packed {
        logic                         send;
        status_t                      status;
        logic [KEY_W-1:0]             out_key;
        logic signed [COORD_BITS-1:0] out_pos_x;
        logic signed [COORD_BITS-1:0] out_pos_y;
        logic signed [COORD_BITS-1:0] out_pos_z;
        logic signed [COORD_BITS-1:0] out_rot_a;
        logic signed [COORD_BITS-1:0] out_rot_b;
        logic signed [COORD_BITS-1:0] out_rot_c;
        logic signed [COORD_BITS-1:0] out_rot_d;
        logic                         out_down;
    } out_item_t;

    // Stored record: coordinate 0 is pos_x, coordinate 6 is rot_d.
    typedef struct packed {
        logic [NUM_COORDS-1:0][COORD_BITS-1:0] coord;
        logic                                  down;
    } record_t;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
    } lane_cmd_t;

    typedef struct packed {
        logic             hit;
        logic [ROW_W-1:0] row;
    } lane_res_t;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } delta_cmd_t;

    typedef struct packed {
        logic done;
        logic changed;
    } delta_res_t;

endpackage

// ----- src/kdcf_search_lane.sv -----
// One search lane: a bank of stored keys, one row read and compared per cycle.
module kdcf_search_lane (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [kdcf_pkg::LANE_W-1:0]     lane_id,
    input  kdcf_pkg::lane_cmd_t             cmd,
    input  logic [kdcf_pkg::KEY_W-1:0]      key,
    input  logic [kdcf_pkg::FILL_W-1:0]     fill_count,
    output kdcf_pkg::lane_res_t             res
);
    import kdcf_pkg::*;

    logic [KEY_W-1:0] key_mem [ROWS];
    logic [KEY_W-1:0] rd_key_reg;
    logic [ROW_W-1:0] rd_row_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] entry_idx;
    logic             in_use;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            key_mem[cmd.wr_row] <= key;
        end
        if (cmd.rd_en)
        begin
            rd_key_reg <= key_mem[cmd.rd_row];
            rd_row_reg <= cmd.rd_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
        end
    end

    // Ignore entries past the fill mark: they were never written.
    assign entry_idx = {rd_row_reg, lane_id};
    assign in_use    = ({1'b0, entry_idx} < fill_count);

    assign res.hit = rd_valid_reg && in_use && (rd_key_reg == key);
    assign res.row = rd_row_reg;

endmodule

// ----- src/kdcf_merge.sv -----
// Merge stage: fold lane hits into one found flag and table slot.
`include "keyed_deadband_change_filter_core_assert.svh"

module kdcf_merge (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  kdcf_pkg::lane_res_t          lane_res [kdcf_pkg::LANES],
    output logic                         found,
    output logic [kdcf_pkg::IDX_W-1:0]   slot
);
    import kdcf_pkg::*;

    logic [LANES-1:0]  hit_vec;
    logic [LANE_W-1:0] sel_lane;
    logic              found_reg;
    logic [IDX_W-1:0]  slot_reg;

    always_comb
    begin
        sel_lane = '0;
        for (int l = LANES - 1; l >= 0; l--)
        begin
            hit_vec[l] = lane_res[l].hit;
            if (lane_res[l].hit)
            begin
                sel_lane = LANE_W'(l);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (|hit_vec)
        begin
            found_reg <= 1'b1;
        end
    end

    // All lanes read the same row in a given cycle.
    always_ff @(posedge clk)
    begin
        if (|hit_vec)
        begin
            slot_reg <= {lane_res[0].row, sel_lane};
        end
    end

    assign found = found_reg;
    assign slot  = slot_reg;

    // Keys are stored only on a miss, so no key sits in two slots.
    `KDCF_ASSERT(a_single_lane_hit, $onehot0(hit_vec))
    `KDCF_ASSERT(a_found_holds, (found_reg && !clear) |=> found_reg)

endmodule

// ----- src/kdcf_delta_unit.sv -----
// Record store and dead-band comparator, one coordinate per cycle.
module kdcf_delta_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kdcf_pkg::delta_cmd_t          cmd,
    input  kdcf_pkg::record_t             new_rec,
    input  logic [kdcf_pkg::THR_W-1:0]    threshold,
    output kdcf_pkg::delta_res_t          res
);
    import kdcf_pkg::*;

    record_t                 rec_mem [TABLE_ENTRIES];
    record_t                 rd_rec_reg;
    logic                    busy_reg;
    logic [CIDX_W-1:0]       cmp_idx_reg;
    logic                    changed_reg;
    logic signed [DIFF_W-1:0] old_c;
    logic signed [DIFF_W-1:0] new_c;
    logic [DIFF_W-1:0]       mag;
    logic                    step_change;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            rec_mem[cmd.wr_addr] <= new_rec;
        end
        if (cmd.start)
        begin
            rd_rec_reg <= rec_mem[cmd.rd_addr];
        end
    end

    // Widen by one bit so the difference is exact.
    always_comb
    begin
        old_c = DIFF_W'($signed(rd_rec_reg.coord[cmp_idx_reg]));
        new_c = DIFF_W'($signed(new_rec.coord[cmp_idx_reg]));
        if (old_c >= new_c)
        begin
            mag = DIFF_W'(old_c - new_c);
        end
        else
        begin
            mag = DIFF_W'(new_c - old_c);
        end
        step_change = (mag > DIFF_W'(threshold)) || (rd_rec_reg.down != new_rec.down);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            cmp_idx_reg <= '0;
            changed_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            busy_reg    <= 1'b1;
            cmp_idx_reg <= '0;
            changed_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            changed_reg <= changed_reg | step_change;
            cmp_idx_reg <= cmp_idx_reg + 1'b1;
            if (cmp_idx_reg == LAST_COORD)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign res.done    = busy_reg && (cmp_idx_reg == LAST_COORD);
    assign res.changed = changed_reg | step_change;

endmodule

// ----- src/keyed_deadband_change_filter_core.sv -----
// Top level of the keyed dead-band change filter: control, search lanes and result register.
// Requests are taken one at a time, only in idle once the previous result is loaded.
//   The scan reads ceil(fill_count/4) rows in the four key lanes (at most 64);
//   an empty table skips scan and drain.
// Reset (rst_n, asynchronous, active low) empties the table at once through the fill
//   count and loads the dead-band threshold with 66; no clearing pass is needed.
`include "keyed_deadband_change_filter_core_assert.svh"

module keyed_deadband_change_filter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_ready,
    input  kdcf_pkg::in_item_t            req_item,
    // response channel
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output kdcf_pkg::out_item_t           rsp_item,
    // threshold register
    input  logic                          cfg_we,
    input  logic [kdcf_pkg::THR_W-1:0]    cfg_wdata
);
    import kdcf_pkg::*;

    state_t               state_reg;
    state_t               state_next;

    in_item_t             item_reg;
    record_t              new_rec;
    logic [THR_W-1:0]     thr_reg;
    logic [FILL_W-1:0]    fill_count_reg;
    logic [ROWCNT_W-1:0]  row_cnt_reg;
    logic [ROWCNT_W-1:0]  rows_needed;
    logic                 last_row;
    logic                 table_full;

    logic                 send_reg;
    status_t              status_reg;
    out_item_t            rsp_item_reg;
    logic                 rsp_valid_reg;

    logic                 accept;
    logic                 out_free;
    logic                 search_rd;
    logic                 do_insert;
    logic                 start_cmp;
    logic                 upd_rec;
    logic                 load_out;

    lane_cmd_t            lane_cmd [LANES];
    lane_res_t            lane_res [LANES];
    logic                 found;
    logic [IDX_W-1:0]     slot;
    delta_cmd_t           delta_cmd;
    delta_res_t           delta_res;

    // ------------------------------------------------------------------
    // Handshake and bookkeeping
    // ------------------------------------------------------------------
    assign accept   = req_valid && req_ready;
    assign out_free = !rsp_valid_reg || rsp_ready;

    // Rows holding live entries: entry i sits in lane i mod 4, row i div 4.
    assign rows_needed = ROWCNT_W'((fill_count_reg + FILL_W'(LANES - 1)) >> LANE_W);
    assign last_row    = ((row_cnt_reg + 1'b1) == rows_needed);
    assign table_full  = (fill_count_reg == FILL_W'(TABLE_ENTRIES));

    assign new_rec.coord = {item_reg.rot_d, item_reg.rot_c, item_reg.rot_b, item_reg.rot_a,
                            item_reg.pos_z, item_reg.pos_y, item_reg.pos_x};
    assign new_rec.down  = item_reg.is_down;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // With an empty table skip the scan altogether.
                    state_next = (fill_count_reg == '0) ? S_DECIDE : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (last_row)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = found ? S_COMPARE : S_RESULT;
            end
            S_COMPARE:
            begin
                if (delta_res.done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        req_ready = 1'b0;
        search_rd = 1'b0;
        do_insert = 1'b0;
        start_cmp = 1'b0;
        upd_rec   = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
            end
            S_SEARCH:
            begin
                search_rd = 1'b1;
            end
            S_DECIDE:
            begin
                start_cmp = found;
                do_insert = !found && !table_full;
            end
            S_COMPARE:
            begin
                upd_rec = delta_res.done && delta_res.changed;
            end
            S_RESULT:
            begin
                load_out = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Lane commands: every lane reads the same row; only the lane that
    // owns the next free slot takes the new key.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_cmd[l].rd_en  = search_rd;
            lane_cmd[l].rd_row = row_cnt_reg[ROW_W-1:0];
            lane_cmd[l].wr_en  = do_insert && (fill_count_reg[LANE_W-1:0] == LANE_W'(l));
            lane_cmd[l].wr_row = fill_count_reg[IDX_W-1:LANE_W];
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        kdcf_search_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .lane_id    (LANE_W'(g)),
            .cmd        (lane_cmd[g]),
            .key        (item_reg.actor_key),
            .fill_count (fill_count_reg),
            .res        (lane_res[g])
        );
    end

    kdcf_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (accept),
        .lane_res (lane_res),
        .found    (found),
        .slot     (slot)
    );

    // Read the stored record on a hit; write on insert or on change.
    assign delta_cmd.start   = start_cmp;
    assign delta_cmd.rd_addr = slot;
    assign delta_cmd.wr_en   = do_insert || upd_rec;
    assign delta_cmd.wr_addr = do_insert ? fill_count_reg[IDX_W-1:0] : slot;

    kdcf_delta_unit u_delta (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (delta_cmd),
        .new_rec   (new_rec),
        .threshold (thr_reg),
        .res       (delta_res)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            thr_reg        <= THR_RESET;
            fill_count_reg <= '0;
            row_cnt_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (do_insert)
            begin
                fill_count_reg <= fill_count_reg + 1'b1;
            end
            if (accept)
            begin
                row_cnt_reg <= '0;
            end
            else if (search_rd)
            begin
                row_cnt_reg <= row_cnt_reg + 1'b1;
            end
            // Hold the result until taken; a new one may replace it the same cycle.
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req_item;
        end
        if (state_reg == S_DECIDE && !found)
        begin
            send_reg <= item_reg.is_down;
            if (table_full)
            begin
                status_reg <= ST_FULL;
            end
            else
            begin
                status_reg <= item_reg.is_down ? ST_NEW_DEAD : ST_NEW_SKIPPED;
            end
        end
        else if (state_reg == S_COMPARE && delta_res.done)
        begin
            send_reg   <= delta_res.changed;
            status_reg <= delta_res.changed ? ST_CHANGED : ST_UNCHANGED;
        end
        if (load_out)
        begin
            rsp_item_reg.send      <= send_reg;
            rsp_item_reg.status    <= status_reg;
            rsp_item_reg.out_key   <= item_reg.actor_key;
            rsp_item_reg.out_pos_x <= item_reg.pos_x;
            rsp_item_reg.out_pos_y <= item_reg.pos_y;
            rsp_item_reg.out_pos_z <= item_reg.pos_z;
            rsp_item_reg.out_rot_a <= item_reg.rot_a;
            rsp_item_reg.out_rot_b <= item_reg.rot_b;
            rsp_item_reg.out_rot_c <= item_reg.rot_c;
            rsp_item_reg.out_rot_d <= item_reg.rot_d;
            rsp_item_reg.out_down  <= item_reg.is_down;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `KDCF_ASSERT_NEVER(a_fill_bound, fill_count_reg > FILL_W'(TABLE_ENTRIES))
    `KDCF_ASSERT(a_fill_step, (fill_count_reg != $past(fill_count_reg)) |-> (fill_count_reg == FILL_W'($past(fill_count_reg) + 1'b1)))
    `KDCF_ASSERT(a_result_source, $rose(rsp_valid_reg) |-> ($past(state_reg) == S_RESULT))
    `KDCF_ASSERT_NEVER(a_insert_when_full, do_insert && table_full)

endmodule

// ----- test/tb.sv -----
// Testbench for the keyed dead-band change filter: directed table, then random traffic vs. a predictor.
`timescale 1ns / 1ps

module tb;
    import kdcf_pkg::*;

    localparam int CYCLE_LIMIT = 500_000;
    localparam int SETTLE_CYCLES = 80;

    localparam logic [31:0] CMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] CMIN = 32'h8000_0000;
    localparam logic [31:0] P66  = 32'd66;
    localparam logic [31:0] N66  = 32'hFFFF_FFBE;
    localparam logic [31:0] P67  = 32'd67;
    localparam logic [31:0] N67  = 32'hFFFF_FFBD;

    localparam logic [KEY_W-1:0] KEY_ZERO  = 64'h0;
    localparam logic [KEY_W-1:0] KEY_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_MIXED = 64'hA5A5_5A5A_0123_4567;
    localparam logic [KEY_W-1:0] KEY_EDGES = 64'h8000_0000_0000_0001;

    // Element NUM_COORDS-1 is pos_x, element 0 is rot_d.
    typedef logic [NUM_COORDS-1:0][COORD_BITS-1:0] coord_vec_t;

    typedef struct {
        logic [KEY_W-1:0] key;
        coord_vec_t       cv;
        logic             down;
        bit               typed;
        logic             send;
        status_t          status;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    in_item_t    req_item;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    out_item_t   rsp_item;
    logic        cfg_we;
    logic [THR_W-1:0] cfg_wdata;

    // Predictor state: stored keys with their last recorded records, and the current dead band.
    logic [KEY_W-1:0] sent_keys [TABLE_ENTRIES];
    in_item_t         sent_recs [TABLE_ENTRIES];
    int               fill_cnt;
    logic [THR_W-1:0] dead_band;

    out_item_t outcome_q[$];
    dir_row_t  directed_rows[19];

    int  mismatches = 0;
    int  items_sent = 0;
    int  outcome_seen[5] = '{default: 0};
    int  cycle_cnt = 0;
    int  stall_left = 0;
    int  stall_pct = 10;
    int  gap_pct;
    bit  calm;
    logic [THR_W-1:0] mid_band;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    keyed_deadband_change_filter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    function automatic coord_vec_t coords_of(in_item_t it);
        return {it.pos_x, it.pos_y, it.pos_z, it.rot_a, it.rot_b, it.rot_c, it.rot_d};
    endfunction

    // A record moves when the dead flag flips or any coordinate strays beyond the band.
    // Differences are taken at 64 bits, so the full signed span never wraps.
    function automatic bit has_moved(in_item_t was, in_item_t now);
        coord_vec_t a;
        coord_vec_t b;
        longint     d;
        a = coords_of(was);
        b = coords_of(now);
        if (was.is_down != now.is_down)
            return 1'b1;
        for (int k = 0; k < NUM_COORDS; k++)
        begin
            d = longint'($signed(a[k])) - longint'($signed(b[k]));
            if (d < 0)
                d = -d;
            if (d > longint'(dead_band))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the filter's verdict on one record and advance the table.
    function automatic out_item_t filter_outcome(in_item_t it);
        out_item_t r;
        int        slot;
        slot = -1;
        for (int i = 0; i < fill_cnt; i++)
        begin
            if (sent_keys[i] == it.actor_key)
            begin
                slot = i;
                break;
            end
        end
        r.out_key = it.actor_key;
        {r.out_pos_x, r.out_pos_y, r.out_pos_z,
         r.out_rot_a, r.out_rot_b, r.out_rot_c, r.out_rot_d} = coords_of(it);
        r.out_down = it.is_down;
        if (slot >= 0)
        begin
            if (has_moved(sent_recs[slot], it))
            begin
                sent_recs[slot] = it;
                r.send   = 1'b1;
                r.status = ST_CHANGED;
            end
            else
            begin
                r.send   = 1'b0;
                r.status = ST_UNCHANGED;
            end
        end
        else if (fill_cnt < TABLE_ENTRIES)
        begin
            sent_keys[fill_cnt] = it.actor_key;
            sent_recs[fill_cnt] = it;
            fill_cnt++;
            r.send   = it.is_down;
            r.status = it.is_down ? ST_NEW_DEAD : ST_NEW_SKIPPED;
        end
        else
        begin
            r.send   = it.is_down;
            r.status = ST_FULL;
        end
        return r;
    endfunction

    // Build the next random record. Outside the fresh_pct share a record revisits a stored key
    // and nudges its coordinates, often around the band edge; the rest are fresh keys with raw content.
    function automatic in_item_t next_record(int fresh_pct);
        in_item_t   it;
        coord_vec_t cv;
        int         slot;
        int         mode;
        longint     off;
        if (fill_cnt == 0 || $urandom_range(0, 99) < fresh_pct)
        begin
            it.actor_key = {$urandom, $urandom};
            for (int k = 0; k < NUM_COORDS; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       cv[k] = CMIN;
                    1:       cv[k] = CMAX;
                    default: cv[k] = $urandom;
                endcase
            end
            {it.pos_x, it.pos_y, it.pos_z, it.rot_a, it.rot_b, it.rot_c, it.rot_d} = cv;
            it.is_down = ($urandom_range(0, 2) == 0);
        end
        else
        begin
            slot = $urandom_range(0, fill_cnt - 1);
            it = sent_recs[slot];
            it.actor_key = sent_keys[slot];
            cv = coords_of(it);
            mode = $urandom_range(0, 9);
            for (int k = 0; k < NUM_COORDS; k++)
            begin
                off = 0;
                if (mode < 3)
                    off = longint'($urandom_range(0, dead_band));
                else
                begin
                    case ($urandom_range(0, 7))
                        4, 5:    off = longint'(dead_band) + longint'($urandom_range(0, 4)) - 2;
                        6:       off = longint'($urandom_range(0, 1000));
                        7:       cv[k] = $urandom;
                        default: off = 0;
                    endcase
                end
                if ($urandom_range(0, 1) == 0)
                    off = -off;
                cv[k] = cv[k] + off[31:0];
            end
            {it.pos_x, it.pos_y, it.pos_z, it.rot_a, it.rot_b, it.rot_c, it.rot_d} = cv;
            if ($urandom_range(0, 6) == 0)
                it.is_down = ~it.is_down;
        end
        return it;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    // Offer one record, hold it until accepted, then file the expected outcome.
    task automatic push_record(in_item_t it, bit typed, logic want_send, status_t want_status);
        out_item_t want;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        do @(posedge clk); while (!req_ready);
        want = filter_outcome(it);
        if (typed)
        begin
            want.send   = want_send;
            want.status = want_status;
        end
        outcome_q.insert(outcome_q.size(), want);
        items_sent++;
    endtask

    task automatic drain_results();
        if (req_valid)
            req_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_threshold(logic [THR_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        dead_band = v;
    endtask

    task automatic random_phase(int count, int fresh_pct);
        for (int n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
                gap_pct = pick_idle_pct();
            // Now and then hold the sender back until the block has gone quiet.
            if (!calm && $urandom_range(0, 99) == 0)
                drain_results();
            push_record(next_record(fresh_pct), 1'b0, 1'b0, ST_UNCHANGED);
        end
    endtask

    task automatic check_outcome(out_item_t got, out_item_t want);
        coord_vec_t gc;
        coord_vec_t wc;
        string      names[NUM_COORDS] = '{"out_rot_d", "out_rot_c", "out_rot_b", "out_rot_a",
                                           "out_pos_z", "out_pos_y", "out_pos_x"};
        gc = {got.out_pos_x, got.out_pos_y, got.out_pos_z,
              got.out_rot_a, got.out_rot_b, got.out_rot_c, got.out_rot_d};
        wc = {want.out_pos_x, want.out_pos_y, want.out_pos_z,
              want.out_rot_a, want.out_rot_b, want.out_rot_c, want.out_rot_d};
        if (got.send !== want.send)
        begin
            $error("send: expected %0b, got %0b", want.send, got.send);
            mismatches++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.out_key !== want.out_key)
        begin
            $error("out_key: expected %h, got %h", want.out_key, got.out_key);
            mismatches++;
        end
        for (int k = 0; k < NUM_COORDS; k++)
        begin
            if (gc[k] !== wc[k])
            begin
                $error("%s: expected %h, got %h", names[k], wc[k], gc[k]);
                mismatches++;
            end
        end
        if (got.out_down !== want.out_down)
        begin
            $error("out_down: expected %0b, got %0b", want.out_down, got.out_down);
            mismatches++;
        end
    endtask

    // Response side: compare every accepted transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("result with no transaction outstanding, out_key %h", rsp_item.out_key);
                mismatches++;
            end
            else
                check_outcome(rsp_item, outcome_q.pop_front());
            if (int'(rsp_item.status) < 5)
                outcome_seen[int'(rsp_item.status)]++;
        end
    end

    // Cycle budget and receiver back-pressure in random bursts.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $error("run did not complete within %0d cycles", CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            if (cycle_cnt % 256 == 0)
                stall_pct = pick_idle_pct();
            if (stall_left == 0 && !calm && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 4);
            if (stall_left != 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        in_item_t it;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_item  = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        fill_cnt  = 0;
        dead_band = THR_RESET;
        gap_pct   = 10;
        calm      = 1'b0;

        // Directed rows run at the reset band of 66. Typed outcomes are the ones that
        // follow at a glance; the rest are left to the predictor.
        directed_rows = '{
            '{KEY_ZERO,  {7{32'd0}},                     1'b0, 1'b1, 1'b0, ST_NEW_SKIPPED},
            '{KEY_ONES,  {7{CMAX}},                      1'b1, 1'b1, 1'b1, ST_NEW_DEAD},
            '{KEY_ZERO,  {7{32'd0}},                     1'b0, 1'b1, 1'b0, ST_UNCHANGED},
            // a step of exactly the band is not a change, either way
            '{KEY_ZERO,  {P66, {6{32'd0}}},              1'b0, 1'b1, 1'b0, ST_UNCHANGED},
            '{KEY_ZERO,  {N66, {6{32'd0}}},              1'b0, 1'b1, 1'b0, ST_UNCHANGED},
            '{KEY_ZERO,  {P67, {6{32'd0}}},              1'b0, 1'b1, 1'b1, ST_CHANGED},
            // walk the one-past-band step through every other coordinate
            '{KEY_ZERO,  {P67, N67, {5{32'd0}}},         1'b0, 1'b0, 1'b0, ST_UNCHANGED},
            '{KEY_ZERO,  {P67, N67, P67, {4{32'd0}}},    1'b0, 1'b0, 1'b0, ST_UNCHANGED},
            '{KEY_ZERO,  {P67, N67, {2{P67}}, {3{32'd0}}}, 1'b0, 1'b0, 1'b0, ST_UNCHANGED},
            '{KEY_ZERO,  {P67, N67, {3{P67}}, {2{32'd0}}}, 1'b0, 1'b0, 1'b0, ST_UNCHANGED},
            '{KEY_ZERO,  {P67, N67, {4{P67}}, 32'd0},    1'b0, 1'b0, 1'b0, ST_UNCHANGED},
            '{KEY_ZERO,  {P67, N67, {5{P67}}},           1'b0, 1'b0, 1'b0, ST_UNCHANGED},
            // dead flag alone makes a change
            '{KEY_ZERO,  {P67, N67, {5{P67}}},           1'b1, 1'b1, 1'b1, ST_CHANGED},
            // full signed span must not wrap
            '{KEY_ONES,  {7{CMIN}},                      1'b1, 1'b1, 1'b1, ST_CHANGED},
            '{KEY_ONES,  {7{CMIN}},                      1'b1, 1'b1, 1'b0, ST_UNCHANGED},
            '{KEY_ONES,  {7{CMIN}},                      1'b0, 1'b1, 1'b1, ST_CHANGED},
            '{KEY_MIXED, {CMIN, CMAX, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000,
                          32'hFFFF_0000},                1'b0, 1'b1, 1'b0, ST_NEW_SKIPPED},
            '{KEY_MIXED, {CMIN, CMAX, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000,
                          32'hFFFF_0042},                1'b0, 1'b1, 1'b0, ST_UNCHANGED},
            '{KEY_EDGES, {CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX},
                                                         1'b1, 1'b1, 1'b1, ST_NEW_DEAD}
        };

        // Hold reset low, then release it on an edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[n])
        begin
            it.actor_key = directed_rows[n].key;
            {it.pos_x, it.pos_y, it.pos_z, it.rot_a, it.rot_b, it.rot_c, it.rot_d} =
                directed_rows[n].cv;
            it.is_down = directed_rows[n].down;
            push_record(it, directed_rows[n].typed, directed_rows[n].send,
                        directed_rows[n].status);
        end

        // Tightest band: any movement at all is a change.
        drain_results();
        set_threshold('0);
        random_phase(250, 20);

        // Widest band: only jumps past half the full span, or a dead-flag flip, get through.
        drain_results();
        set_threshold(31'h7FFF_FFFF);
        random_phase(250, 20);

        // Mid band with many fresh keys, enough to fill the table and overflow it.
        drain_results();
        mid_band = THR_W'($urandom_range(1, 32'h000F_FFFF));
        set_threshold(mid_band);
        random_phase(300, 60);

        // Back to the reset band, with both sides running flat out.
        drain_results();
        calm = 1'b1;
        set_threshold(THR_RESET);
        random_phase(150, 30);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d transactions at bands 66, 0, max, %0d and 66 again.",
                 items_sent, mid_band);
        $display("Outcomes: unchanged %0d, new skipped %0d, new dead %0d, changed %0d, full %0d.",
                 outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
                 outcome_seen[4]);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
